/* design/u8u16_pkg.sv */
// ---------------------------------------------------------------------------
// u8u16_pkg
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
// ---------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

	localparam int unsigned TEXT_W  = 8;
	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned POINT_W = 21;

	localparam logic [UNIT_W-1:0]  REPL_UNIT  = 16'hFFFD;
	localparam logic [UNIT_W-1:0]  HI_SURR    = 16'hD800;
	localparam logic [UNIT_W-1:0]  LO_SURR    = 16'hDC00;
	localparam logic [POINT_W-1:0] SUPP_BASE  = 21'h010000;
	localparam logic [POINT_W-1:0] CODE_LIMIT = 21'h110000;

	// one buffered output word
	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              run_last;
		logic              text_end;
	} unit_t;

endpackage : u8u16_pkg

`default_nettype wire

/* design/utf8_to_utf16_transcoder.sv */
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Converts a UTF-8 byte stream into UTF-16 code units.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per word in tdata; tlast marks the final
//   byte of a text. m_axis carries one UTF-16 code unit per word in tdata;
//   tuser is 1 on the last unit caused by an input byte, tlast on the last
//   unit of the text.
//   A byte that completes a code point passes the input register and then the
//   two-word output buffer before its first unit shows on m_axis.
//   Throughput: one byte per cycle in, one unit per cycle out while m_axis_tready
//   holds high. A byte that emits units is taken as soon as the output buffer
//   has room for them, counting the word leaving in the same cycle; a surrogate
//   pair fills both buffer slots, which the three bytes before it leave free.
//   Reset clears the open sequence, the input register and the buffer.
//   When the receiver stalls, the buffer fills and s_axis_tready drops; no
//   word is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [TEXT_W-1:0] s_axis_tdata,   // [7:0] text_byte
	input  wire logic              s_axis_tlast,   // final_byte
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [UNIT_W-1:0]      m_axis_tdata,   // [15:0] code_unit
	output logic                   m_axis_tuser,   // [0] run_last
	output logic                   m_axis_tlast    // text_end
);

	// input register
	logic              valid_s1;
	logic [TEXT_W-1:0] byte_s1;
	logic              fin_s1;

	// sequence state
	logic [POINT_W-1:0] acc_q;
	logic [1:0]         pend_q;

	// output buffer
	unit_t      buf_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	// decode
	logic [POINT_W-1:0] acc_d;
	logic [1:0]         need_d;
	logic [POINT_W-1:0] acc_next;
	logic [1:0]         pend_next;
	logic [1:0]         n_units;
	unit_t              u0;
	unit_t              u1;
	logic [POINT_W-1:0] supp_off;

	logic       pop;
	logic [2:0] free_slots;
	logic       consume;

	always_comb begin
		if (pend_q == 2'd0) begin
			if (byte_s1[7] == 1'b0) begin
				acc_d  = {13'd0, byte_s1};
				need_d = 2'd0;
			end else if (byte_s1[7:5] == 3'b110) begin
				acc_d  = {16'd0, byte_s1[4:0]};
				need_d = 2'd1;
			end else if (byte_s1[7:4] == 4'b1110) begin
				acc_d  = {17'd0, byte_s1[3:0]};
				need_d = 2'd2;
			end else begin
				acc_d  = {18'd0, byte_s1[2:0]};
				need_d = 2'd3;
			end
		end else begin
			acc_d  = {acc_q[POINT_W-7:0], byte_s1[5:0]};
			need_d = pend_q - 2'd1;
		end
	end

	assign supp_off = acc_d - SUPP_BASE;

	always_comb begin
		acc_next  = '0;
		pend_next = 2'd0;
		n_units   = 2'd1;
		u0        = '{unit: REPL_UNIT, run_last: 1'b1, text_end: fin_s1};
		u1        = '{unit: REPL_UNIT, run_last: 1'b1, text_end: fin_s1};
		if (need_d != 2'd0) begin
			// sequence still open; cut short only at the end of text
			if (!fin_s1) begin
				acc_next  = acc_d;
				pend_next = need_d;
				n_units   = 2'd0;
			end
		end else if (acc_d < SUPP_BASE) begin
			u0.unit = acc_d[UNIT_W-1:0];
		end else if (acc_d < CODE_LIMIT) begin
			n_units     = 2'd2;
			u0.unit     = HI_SURR | {6'd0, supp_off[19:10]};
			u0.run_last = 1'b0;
			u0.text_end = 1'b0;
			u1.unit     = LO_SURR | {6'd0, supp_off[9:0]};
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign free_slots    = 3'd2 - {1'b0, cnt_q} + {2'd0, pop};
	assign consume       = valid_s1 && ({1'b0, n_units} <= free_slots);
	assign s_axis_tready = !valid_s1 || consume;

	assign m_axis_tdata = buf_q[rd_q].unit;
	assign m_axis_tuser = buf_q[rd_q].run_last;
	assign m_axis_tlast = buf_q[rd_q].text_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			fin_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= 2'd0;
		end else if (consume) begin
			acc_q  <= acc_next;
			pend_q <= pend_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (consume) begin
				wr_q <= wr_q ^ n_units[0];
			end
			cnt_q <= cnt_q + (consume ? n_units : 2'd0) - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (consume && n_units != 2'd0) begin
			buf_q[wr_q] <= u0;
		end
		if (consume && n_units == 2'd2) begin
			buf_q[~wr_q] <= u1;
		end
	end

endmodule : utf8_to_utf16_transcoder

`default_nettype wire

/* design/u8u16_checker.sv */
// ---------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the UTF-8 to UTF-16 transcoder.
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_checker
	import u8u16_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [UNIT_W-1:0] m_axis_tdata,
	input wire logic              m_axis_tuser,
	input wire logic              m_axis_tlast
);

	logic m_word;
	assign m_word = m_axis_tvalid && m_axis_tready;

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// input stalls only while output words are waiting
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// end of text is always the last unit of its byte
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("text end without run end");

	// only a high surrogate can be a non-final unit of a byte
	a_mid_is_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:10] == HI_SURR[15:10])
		else $error("non-final unit is not a high surrogate");

	// low surrogate follows at once, already buffered
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_word && !m_axis_tuser |=> m_axis_tvalid && m_axis_tuser
			&& m_axis_tdata[15:10] == LO_SURR[15:10])
		else $error("low surrogate missing after high surrogate");

endmodule : u8u16_checker

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/utf8_to_utf16_transcoder_tb.sv */
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Self-checking bench for the UTF-8 to UTF-16 transcoder.
// A short table of hand-picked bytes is followed by random texts. Most texts
// are well-formed sequences; the rest are broken, overlong, out-of-range or
// cut short by the end of the text. A behavioral decoder predicts every unit,
// and the sink compares each output word with the oldest prediction.
// ---------------------------------------------------------------------------

module utf8_to_utf16_transcoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8u16_pkg::*;

	localparam int RAND_BYTES = 650;
	localparam int TAIL_BYTES = 60;
	localparam int HOLD_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [7:0]  b;
		logic        fin;
		bit          typed;
		logic [15:0] unit;
	} byte_row_t;

	// typed rows carry their single expected unit; the rest use the decoder
	byte_row_t byte_rows [0:23] = '{
		'{8'h00, 1'b0, 1'b1, 16'h0000},
		'{8'h7F, 1'b0, 1'b1, 16'h007F},
		'{8'hC2, 1'b0, 1'b0, 16'h0000},
		'{8'hA9, 1'b0, 1'b0, 16'h0000},
		'{8'hE2, 1'b0, 1'b0, 16'h0000},
		'{8'h82, 1'b0, 1'b0, 16'h0000},
		'{8'hAC, 1'b0, 1'b0, 16'h0000},
		'{8'hF4, 1'b0, 1'b0, 16'h0000},
		'{8'h8F, 1'b0, 1'b0, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 16'h0000},
		'{8'hFF, 1'b0, 1'b0, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 16'h0000},
		'{8'hBF, 1'b0, 1'b1, 16'hFFFD},
		'{8'hED, 1'b0, 1'b0, 16'h0000},
		'{8'hA0, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b1, 1'b1, 16'hFFFD},
		'{8'hE0, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b1, 1'b1, 16'hFFFD},
		'{8'hC0, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b0, 1'b0, 16'h0000},
		'{8'h41, 1'b1, 1'b1, 16'h0041}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [TEXT_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [UNIT_W-1:0] m_axis_tdata;
	logic              m_axis_tuser;
	logic              m_axis_tlast;

	// decoder state
	logic [POINT_W-1:0] point_acc = '0;
	logic [1:0]         cont_left = '0;

	unit_t pending_units[$];

	logic hold_off = 1'b0;
	logic quiet = 1'b0;
	int   n_bytes = 0;
	int   n_units = 0;
	int   n_pairs = 0;
	int   n_repl = 0;
	int   n_texts = 0;
	int   n_errors = 0;

	utf8_to_utf16_transcoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// decode one byte, queue the units it produces, return how many
	function automatic int decode_byte(input logic [7:0] b, input logic fin);
		logic [POINT_W-1:0] acc;
		logic [POINT_W-1:0] off;
		logic [1:0]         need;
		int                 cnt;
		cnt = 0;
		if (cont_left == 2'd0) begin
			if (!b[7]) begin
				acc = POINT_W'(b);
				need = 2'd0;
			end else if (b[7:5] == 3'b110) begin
				acc = POINT_W'(b[4:0]);
				need = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				acc = POINT_W'(b[3:0]);
				need = 2'd2;
			end else begin
				// any other lead, stray continuations too, opens a 4-byte sequence
				acc = POINT_W'(b[2:0]);
				need = 2'd3;
			end
		end else begin
			acc = {point_acc[POINT_W-7:0], b[5:0]};
			need = cont_left - 2'd1;
		end
		if (need != 2'd0 && !fin) begin
			point_acc = acc;
			cont_left = need;
		end else begin
			point_acc = '0;
			cont_left = 2'd0;
			if (need != 2'd0 || acc >= CODE_LIMIT) begin
				pending_units.push_back('{REPL_UNIT, 1'b1, fin});
				cnt = 1;
			end else if (acc < SUPP_BASE) begin
				pending_units.push_back('{acc[UNIT_W-1:0], 1'b1, fin});
				cnt = 1;
			end else begin
				off = acc - SUPP_BASE;
				pending_units.push_back('{HI_SURR | {6'd0, off[19:10]}, 1'b0, 1'b0});
				pending_units.push_back('{LO_SURR | {6'd0, off[9:0]}, 1'b1, fin});
				cnt = 2;
			end
		end
		return cnt;
	endfunction

	// offer one byte, decode it once taken, maybe idle afterwards
	task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
			input logic [15:0] unit);
		int cnt;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		cnt = decode_byte(b, fin);
		if (typed && cnt > 0)
			pending_units[pending_units.size()-1] = '{unit, 1'b1, fin};
		n_bytes++;
		if (fin)
			n_texts++;
		if (!quiet && !hold_off && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// word sink: checks and random back-pressure
	initial begin
		int  stall_left;
		bit  rdy;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				n_units++;
				if (!m_axis_tuser)
					n_pairs++;
				if (m_axis_tdata == REPL_UNIT)
					n_repl++;
				if (pending_units.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("unexpected word: unit %h run_last %b text_end %b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					unit_t want;
					want = pending_units.pop_front();
					if (m_axis_tdata !== want.unit || m_axis_tuser !== want.run_last ||
							m_axis_tlast !== want.text_end) begin
						n_errors++;
						if (n_errors <= MAX_REPORTS)
							$display("mismatch at word %0d: expected %h/%b/%b got %h/%b/%b",
								n_units, want.unit, want.run_last, want.text_end,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				rdy = 1'b0;
			end else begin
				rdy = !hold_off;
			end
			m_axis_tready <= rdy;
		end
	end

	// long receiver hold-off so the output buffer fills and tready drops
	initial begin
		wait (n_bytes >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [7:0]         seq[$];
		logic [POINT_W-1:0] cp;
		int                 kind;
		int                 keep;
		int                 guard;
		bit                 end_text;
		bit                 drained;
		drained = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (byte_rows[i])
			send_byte(byte_rows[i].b, byte_rows[i].fin, byte_rows[i].typed,
				byte_rows[i].unit);

		while (n_bytes < $size(byte_rows) + RAND_BYTES) begin
			seq = {};
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					seq.push_back(8'($urandom_range(0, 127)));
				end
				3: begin
					cp = POINT_W'($urandom_range('h80, 'h7FF));
					seq.push_back({3'b110, cp[10:6]});
					seq.push_back({2'b10, cp[5:0]});
				end
				4, 5: begin
					cp = POINT_W'($urandom_range('h800, 'hFFFF));
					seq.push_back({4'b1110, cp[15:12]});
					seq.push_back({2'b10, cp[11:6]});
					seq.push_back({2'b10, cp[5:0]});
				end
				6, 7: begin
					cp = POINT_W'($urandom_range('h10000, 'h10FFFF));
					seq.push_back({5'b11110, cp[20:18]});
					seq.push_back({2'b10, cp[17:12]});
					seq.push_back({2'b10, cp[11:6]});
					seq.push_back({2'b10, cp[5:0]});
				end
				8: begin
					// noise, including 11111xxx leads and stray continuations
					repeat ($urandom_range(1, 4))
						seq.push_back(8'($urandom));
				end
				default: begin
					// 4-byte form over the full 21-bit space: overlong and out of range
					cp = POINT_W'($urandom);
					seq.push_back({5'b11110, cp[20:18]});
					seq.push_back({2'b10, cp[17:12]});
					seq.push_back({2'b10, cp[11:6]});
					seq.push_back({2'b10, cp[5:0]});
				end
			endcase
			if (seq.size() > 1 && $urandom_range(0, 7) == 0)
				seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom);
			end_text = ($urandom_range(0, 11) == 0);
			if (end_text && seq.size() > 1 && $urandom_range(0, 2) == 0) begin
				keep = $urandom_range(1, seq.size() - 1);
				while (seq.size() > keep)
					void'(seq.pop_back());
			end
			foreach (seq[i])
				send_byte(seq[i], end_text && i == seq.size() - 1, 1'b0, 16'h0000);
			if (n_bytes >= $size(byte_rows) + RAND_BYTES - TAIL_BYTES)
				quiet <= 1'b1;
			// sender pause: let everything drain once mid-run
			if (!drained && n_bytes >= 500) begin
				drained = 1'b1;
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_units.size() != 0)
					@(posedge clk);
			end
		end

		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (pending_units.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);

		$display("%0d bytes in %0d texts, %0d units checked", n_bytes, n_texts, n_units);
		$display("%0d surrogate pairs, %0d replacement units, %0d mismatches",
			n_pairs, n_repl, n_errors);
		if (n_errors == 0 && pending_units.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
